### sv/dmpd_pkg.sv
`default_nettype none

package dmpd_pkg;

	// Request operation codes
	localparam logic [1:0] MODE_BYTE  = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_NOP   = 2'd3;

	// Request word
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
		logic [6:0] read_index;
	} req_t;

	// Response word
	typedef struct packed {
		logic       packet_ready;
		logic       packet_done;
		logic       done_kind;
		logic [7:0] hex_first;
		logic [7:0] hex_second;
		logic [7:0] hex_third;
		logic [7:0] hex_fourth;
		logic [6:0] text_length;
		logic [7:0] read_char;
	} rsp_t;

	// Result stage contents; read data comes from the text buffer register
	typedef struct packed {
		logic       packet_ready;
		logic       packet_done;
		logic       done_kind;
		logic [7:0] hex_first;
		logic [7:0] hex_second;
		logic [7:0] hex_third;
		logic [7:0] hex_fourth;
		logic [6:0] text_length;
		logic       rd_sel;
	} res_s1_t;

endpackage

`default_nettype wire

### sv/dmpd_skid.sv
`default_nettype none

module dmpd_skid (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid,
	output logic                stall,
	input  wire dmpd_pkg::req_t data,
	input  wire logic           take,
	output logic                item_valid,
	output dmpd_pkg::req_t      item
);
	import dmpd_pkg::*;

	logic skid_valid_q;
	req_t skid_q;

	// Stall is registered so the request side never waits on the response side
	assign stall      = skid_valid_q;
	assign item_valid = skid_valid_q | valid;
	assign item       = skid_valid_q ? skid_q : data;

	// Hold one word when the consumer cannot take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (valid && !take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q && valid && !take) begin
			skid_q <= data;
		end
	end

endmodule

`default_nettype wire

### sv/dmpd_tmem.sv
`default_nettype none

module dmpd_tmem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [7:0]         rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### sv/dmpd_fsm.sv
`default_nettype none

module dmpd_fsm #(
	parameter int TEXT_DEPTH = 128,
	parameter int AW         = 7
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	input  wire dmpd_pkg::req_t item,
	input  wire logic           adv,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic [7:0]          mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr,
	output logic                res_valid_s1,
	output dmpd_pkg::res_s1_t   res_s1
);
	import dmpd_pkg::*;

	localparam int TEXT_LIMIT = (TEXT_DEPTH < 127) ? TEXT_DEPTH : 127;
	localparam int CW         = (AW > 7) ? AW : 7;

	localparam logic [7:0] HDR_HEX  = 8'hFF;
	localparam logic [7:0] TRL_HEX  = 8'hFE;
	localparam logic [7:0] HDR_TEXT = 8'h40;
	localparam logic [7:0] CHR_CR   = 8'h0D;
	localparam logic [7:0] CHR_LF   = 8'h0A;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_HEX  = 2'd1;
	localparam logic [1:0] KIND_TEXT = 2'd2;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_BODY  = 2'd1;
	localparam logic [1:0] PH_TRAIL = 2'd2;

	logic [1:0]      kind_q, kind_d;
	logic [1:0]      hex_phase_q, hex_phase_d;
	logic [1:0]      hex_pos_q, hex_pos_d;
	logic [1:0]      text_phase_q, text_phase_d;
	logic [6:0]      text_pos_q, text_pos_d;
	logic            ready_q, ready_d;
	logic [3:0][7:0] hex_q, hex_d;

	logic            fire;
	logic            hex_en, text_en;
	logic            hex_done, text_done;
	logic            rd_sel;
	logic [7:0]      b;
	logic [CW-1:0]   wext, rext;

	assign fire = item_valid & adv;
	assign b    = item.rx_byte;

	// Text buffer addressing
	assign wext      = CW'(text_pos_q);
	assign rext      = CW'(item.read_index);
	assign mem_waddr = wext[AW-1:0];
	assign mem_raddr = rext[AW-1:0];
	assign mem_wdata = b;
	assign mem_re    = fire && (item.mode == MODE_READ);

	// Next-state logic for one word
	always_comb begin
		kind_d       = kind_q;
		hex_phase_d  = hex_phase_q;
		hex_pos_d    = hex_pos_q;
		text_phase_d = text_phase_q;
		text_pos_d   = text_pos_q;
		ready_d      = ready_q;
		hex_d        = hex_q;
		hex_en       = 1'b0;
		text_en      = 1'b0;
		hex_done     = 1'b0;
		text_done    = 1'b0;
		mem_we       = 1'b0;
		rd_sel       = 1'b0;
		if (fire) begin
			unique case (item.mode)
				MODE_BYTE: begin
					hex_en  = ((kind_q == KIND_NONE) && (b == HDR_HEX)) || (kind_q == KIND_HEX);
					text_en = ((kind_q == KIND_NONE) && (b == HDR_TEXT)) || (kind_q == KIND_TEXT);
					if (kind_q == KIND_NONE) begin
						if (b == HDR_HEX) begin
							kind_d = KIND_HEX;
						end else if (b == HDR_TEXT) begin
							kind_d = KIND_TEXT;
						end
					end
					// hex packet: header, four payload bytes, trailer
					if (hex_en) begin
						unique case (hex_phase_q)
							PH_IDLE: begin
								if (b == HDR_HEX && !ready_q) begin
									hex_phase_d = PH_BODY;
									hex_pos_d   = 2'd0;
								end
							end
							PH_BODY: begin
								hex_d[hex_pos_q] = b;
								hex_pos_d        = 2'(hex_pos_q + 2'd1);
								if (hex_pos_q == 2'd3) begin
									hex_phase_d = PH_TRAIL;
								end
							end
							PH_TRAIL: begin
								if (b == TRL_HEX) begin
									hex_phase_d = PH_IDLE;
									ready_d     = 1'b1;
									kind_d      = KIND_NONE;
									hex_done    = 1'b1;
								end
							end
							default: ;
						endcase
					end
					// text packet: header, chars up to CR, then LF
					if (text_en) begin
						unique case (text_phase_q)
							PH_IDLE: begin
								if (b == HDR_TEXT && !ready_q) begin
									text_phase_d = PH_BODY;
									text_pos_d   = 7'd0;
								end
							end
							PH_BODY: begin
								if (b == CHR_CR) begin
									text_phase_d = PH_TRAIL;
								end else if (text_pos_q < 7'(TEXT_LIMIT)) begin
									mem_we     = 1'b1;
									text_pos_d = 7'(text_pos_q + 7'd1);
								end
							end
							PH_TRAIL: begin
								if (b == CHR_LF) begin
									text_phase_d = PH_IDLE;
									ready_d      = 1'b1;
									kind_d       = KIND_NONE;
									text_done    = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				MODE_CLEAR: ready_d = 1'b0;
				MODE_READ: begin
					rd_sel = (CW + 1)'(item.read_index) < (CW + 1)'(TEXT_DEPTH);
				end
				MODE_NOP: ;
				default: ;
			endcase
		end
	end

	// Deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q       <= KIND_NONE;
			hex_phase_q  <= PH_IDLE;
			hex_pos_q    <= 2'd0;
			text_phase_q <= PH_IDLE;
			text_pos_q   <= 7'd0;
			ready_q      <= 1'b0;
			hex_q        <= '0;
		end else begin
			kind_q       <= kind_d;
			hex_phase_q  <= hex_phase_d;
			hex_pos_q    <= hex_pos_d;
			text_phase_q <= text_phase_d;
			text_pos_q   <= text_pos_d;
			ready_q      <= ready_d;
			hex_q        <= hex_d;
		end
	end

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (adv) begin
			res_valid_s1 <= item_valid;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1.packet_ready <= ready_d;
			res_s1.packet_done  <= hex_done | text_done;
			res_s1.done_kind    <= text_done;
			res_s1.hex_first    <= hex_d[0];
			res_s1.hex_second   <= hex_d[1];
			res_s1.hex_third    <= hex_d[2];
			res_s1.hex_fourth   <= hex_d[3];
			res_s1.text_length  <= text_pos_d;
			res_s1.rd_sel       <= rd_sel;
		end
	end

`ifndef SYNTHESIS
	a_done_sets_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 && res_s1.packet_done |-> res_s1.packet_ready)
		else $error("completed packet without ready flag");

	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		text_pos_q <= 7'(TEXT_LIMIT))
		else $error("text length beyond limit");

	a_idle_phases: assert property (@(posedge clk) disable iff (!arst_n)
		kind_q == KIND_NONE |-> hex_phase_q == PH_IDLE && text_phase_q == PH_IDLE)
		else $error("packet phase active with no kind selected");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_CLEAR |=> !res_s1.packet_ready && !ready_q)
		else $error("clear access left ready flag set");
`endif

endmodule

`default_nettype wire

### sv/dual_mode_packet_deframer_core.sv
// A response word is valid once its request word reaches the result register, which is the
// accepting edge unless a stalled response holds it back. Throughput: one request word per
// cycle while responses are not stalled; every request gives exactly one response.
// Request stall comes from a one-word skid register: while a response waits, one more request
// is held there and further requests stall. Reset clears packet state, ready flag and hex
// payload; the text buffer is not cleared and its entries are defined once written.
`default_nettype none

module dual_mode_packet_deframer_core #(
	parameter int TEXT_DEPTH = 128
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire dmpd_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output dmpd_pkg::rsp_t      rsp
);
	import dmpd_pkg::*;

	localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

	logic          item_valid;
	req_t          item;
	logic          adv;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;
	logic          res_valid_s1;
	res_s1_t       res_s1;

	// Result stage moves when empty or when the response is taken
	assign adv = !res_valid_s1 || !rsp_stall;

	dmpd_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (req_valid),
		.stall      (req_stall),
		.data       (req),
		.take       (adv),
		.item_valid (item_valid),
		.item       (item)
	);

	dmpd_fsm #(
		.TEXT_DEPTH (TEXT_DEPTH),
		.AW         (AW)
	) u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.adv          (adv),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.res_valid_s1 (res_valid_s1),
		.res_s1       (res_s1)
	);

	dmpd_tmem #(
		.DEPTH (TEXT_DEPTH),
		.AW    (AW)
	) u_tmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Response word assembly
	assign rsp_valid        = res_valid_s1;
	assign rsp.packet_ready = res_s1.packet_ready;
	assign rsp.packet_done  = res_s1.packet_done;
	assign rsp.done_kind    = res_s1.done_kind;
	assign rsp.hex_first    = res_s1.hex_first;
	assign rsp.hex_second   = res_s1.hex_second;
	assign rsp.hex_third    = res_s1.hex_third;
	assign rsp.hex_fourth   = res_s1.hex_fourth;
	assign rsp.text_length  = res_s1.text_length;
	assign rsp.read_char    = res_s1.rd_sel ? mem_rdata : 8'd0;

endmodule

`default_nettype wire
